// ===== design/ptqk_pkg.sv =====
// Shared types and constants for the point-to-quad-key pipeline.
`timescale 1ns / 1ps

package ptqk_pkg;

    // Coordinate and region word, key and level widths as seen on the ports
    localparam int WORD_BITS = 32;
    localparam int KEY_BITS  = 63;
    localparam int LVL_BITS  = 5;

    // Region register indexes on the config channel
    localparam logic [7:0] REG_MIN_X = 8'd0;
    localparam logic [7:0] REG_MIN_Y = 8'd1;
    localparam logic [7:0] REG_MAX_X = 8'd2;
    localparam logic [7:0] REG_MAX_Y = 8'd3;

    // How the cell of one axis is formed at the end of the pipe
    typedef enum logic [1:0] {
        CELL_ZERO = 2'd0,
        CELL_FULL = 2'd1,
        CELL_DIV  = 2'd2
    } cell_mode_t;

    // Sideband that travels next to the dividers
    typedef struct packed {
        logic [LVL_BITS-1:0] lvl;
        cell_mode_t          x_mode;
        cell_mode_t          y_mode;
        logic                bad;
    } side_t;

endpackage

// ===== design/ptqk_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module ptqk_div
    import ptqk_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [WORD_BITS-1:0]  in_hi,
    input  logic [COORD_BITS-1:0] in_lo,
    input  logic [WORD_BITS-1:0]  in_div,
    output logic                  out_valid,
    output logic [COORD_BITS-1:0] out_quo
);

    logic                  valid_reg [1:COORD_BITS];
    logic [WORD_BITS-1:0]  rem_reg   [1:COORD_BITS];
    logic [COORD_BITS-1:0] lo_reg    [1:COORD_BITS];
    logic [WORD_BITS-1:0]  div_reg   [1:COORD_BITS];
    logic [COORD_BITS-1:0] quo_reg   [1:COORD_BITS];

    genvar k;
    generate
        for (k = 0; k < COORD_BITS; k++)
        begin : g_stage
            logic                  src_valid;
            logic [WORD_BITS-1:0]  src_rem;
            logic [COORD_BITS-1:0] src_lo;
            logic [WORD_BITS-1:0]  src_div;
            logic [COORD_BITS-1:0] src_quo;
            logic [WORD_BITS:0]    trial;
            logic                  ge;
            logic [WORD_BITS:0]    diff;

            // Pick the stage source: ports for the first stage
            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_rem   = in_hi;
                assign src_lo    = in_lo;
                assign src_div   = in_div;
                assign src_quo   = '0;
            end
            else
            begin : g_next
                assign src_valid = valid_reg[k];
                assign src_rem   = rem_reg[k];
                assign src_lo    = lo_reg[k];
                assign src_div   = div_reg[k];
                assign src_quo   = quo_reg[k];
            end

            // Shift in the next dividend bit and try the subtract
            assign trial = {src_rem, src_lo[COORD_BITS-1]};
            assign ge    = (trial >= {1'b0, src_div});
            assign diff  = trial - {1'b0, src_div};

            // Advance the valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k+1] <= 1'b0;
                end
                else
                begin
                    valid_reg[k+1] <= src_valid;
                end
            end

            // Advance the payload
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
                lo_reg[k+1]  <= {src_lo[COORD_BITS-2:0], 1'b0};
                div_reg[k+1] <= src_div;
                quo_reg[k+1] <= {src_quo[COORD_BITS-2:0], ge};
            end
        end
    endgenerate

    assign out_valid = valid_reg[COORD_BITS];
    assign out_quo   = quo_reg[COORD_BITS];

endmodule

// ===== design/ptqk_keygen.sv =====
// Cell selection, bit interleave and key framing; holds the result registers.
`timescale 1ns / 1ps

module ptqk_keygen
    import ptqk_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int MAX_LEVEL  = 31
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  side_t                 side,
    input  logic [COORD_BITS-1:0] quo_x,
    input  logic [COORD_BITS-1:0] quo_y,
    output logic                  done,
    output logic [KEY_BITS-1:0]   tile_key,
    output logic                  degenerate_bounds
);

    logic                  done_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic                  bad_reg;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;
    logic [WORD_BITS-1:0]  cx;
    logic [WORD_BITS-1:0]  cy;
    logic [2*WORD_BITS-1:0] morton;
    logic [LVL_BITS-1:0]   lvl;
    logic [6:0]            shamt;
    logic [2*WORD_BITS-1:0] key_next;

    // Select the cell of each axis
    always_comb
    begin
        case (side.x_mode)
            CELL_FULL: cell_x = '1;
            CELL_DIV:  cell_x = quo_x;
            default:   cell_x = '0;
        endcase
        case (side.y_mode)
            CELL_FULL: cell_y = '1;
            CELL_DIV:  cell_y = quo_y;
            default:   cell_y = '0;
        endcase
    end

    // Left-align cells and interleave, y above x in each pair
    assign cx = WORD_BITS'(cell_x) << (WORD_BITS - COORD_BITS);
    assign cy = WORD_BITS'(cell_y) << (WORD_BITS - COORD_BITS);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            morton[2*i]   = cx[i];
            morton[2*i+1] = cy[i];
        end
    end

    // Clamp the depth, keep the top bits and set the marker
    assign lvl   = (side.lvl > LVL_BITS'(MAX_LEVEL)) ? LVL_BITS'(MAX_LEVEL) : side.lvl;
    assign shamt = 7'd64 - {1'b0, lvl, 1'b0};

    always_comb
    begin
        key_next = 64'd1 << {lvl, 1'b0};
        if (lvl != '0)
        begin
            key_next = key_next | (morton >> shamt);
        end
    end

    // Register the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next[KEY_BITS-1:0];
        bad_reg <= side.bad;
    end

    assign done              = done_reg;
    assign tile_key          = key_reg;
    assign degenerate_bounds = bad_reg;

endmodule

// ===== design/point_to_quad_key_core.sv =====
// Top level: region registers, offset and range stages, dividers, key output.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  command  | in        | start high, busy low   | point_x, point_y, level
//  result   | out       | done, one-cycle beat   | tile_key, degenerate_bounds
//  config   | in        | cfg_valid && cfg_ready | cfg_index, cfg_data
//
// A point may be issued every cycle; busy is always low.
// Each result beat follows its start beat through one offset stage, one
// range/numerator stage, COORD_BITS divider stages and one key stage.
// The divider depth, one quotient bit per stage, sets the latency.
// Reset clears all valid bits and loads the default region; beats in flight are dropped.
// The receiver cannot stall, so the pipe never holds.
`timescale 1ns / 1ps

module point_to_quad_key_core
    import ptqk_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int MAX_LEVEL  = 31
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] point_x,
    input  logic signed [WORD_BITS-1:0] point_y,
    input  logic [LVL_BITS-1:0]         level,
    output logic                        done,
    output logic [KEY_BITS-1:0]         tile_key,
    output logic                        degenerate_bounds,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [7:0]                  cfg_index,
    input  logic [WORD_BITS-1:0]        cfg_data
);

    localparam int LATENCY = COORD_BITS + 3;

    logic signed [WORD_BITS-1:0] min_x_reg;
    logic signed [WORD_BITS-1:0] min_y_reg;
    logic signed [WORD_BITS-1:0] max_x_reg;
    logic signed [WORD_BITS-1:0] max_y_reg;

    logic                      s1_valid_reg;
    logic signed [WORD_BITS:0] dx_reg;
    logic signed [WORD_BITS:0] dy_reg;
    logic signed [WORD_BITS:0] wx_reg;
    logic signed [WORD_BITS:0] wy_reg;
    logic [LVL_BITS-1:0]       lvl_reg;

    logic                  s2_valid_reg;
    side_t                 side_s2_reg;
    logic [WORD_BITS-1:0]  hi_x_reg;
    logic [WORD_BITS-1:0]  hi_y_reg;
    logic [COORD_BITS-1:0] lo_x_reg;
    logic [COORD_BITS-1:0] lo_y_reg;
    logic [WORD_BITS-1:0]  div_x_reg;
    logic [WORD_BITS-1:0]  div_y_reg;

    side_t                 side_pipe_reg [1:COORD_BITS];
    logic                  qx_valid;
    logic                  qy_valid;
    logic [COORD_BITS-1:0] quo_x;
    logic [COORD_BITS-1:0] quo_y;

    logic [WORD_BITS+COORD_BITS-1:0] num_x;
    logic [WORD_BITS+COORD_BITS-1:0] num_y;
    side_t                           side_s2_next;

    // Classify one axis against its region
    function automatic cell_mode_t classify(
        input logic signed [WORD_BITS:0] d,
        input logic signed [WORD_BITS:0] w
    );
        cell_mode_t m;
        if (w <= 0 || d <= 0)
        begin
            m = CELL_ZERO;
        end
        else if (d >= w)
        begin
            m = CELL_FULL;
        end
        else
        begin
            m = CELL_DIV;
        end
        return m;
    endfunction

    // Scaled numerator d * (2^COORD_BITS - 1)
    function automatic logic [WORD_BITS+COORD_BITS-1:0] scale(
        input logic signed [WORD_BITS:0] d
    );
        logic [WORD_BITS+COORD_BITS-1:0] dz;
        dz = (WORD_BITS+COORD_BITS)'(d[WORD_BITS-1:0]);
        return (dz << COORD_BITS) - dz;
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Region registers; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            max_x_reg <= 32'sd65535;
            max_y_reg <= 32'sd65535;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Stage 1: offsets and region widths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= (WORD_BITS+1)'(point_x) - (WORD_BITS+1)'(min_x_reg);
        dy_reg  <= (WORD_BITS+1)'(point_y) - (WORD_BITS+1)'(min_y_reg);
        wx_reg  <= (WORD_BITS+1)'(max_x_reg) - (WORD_BITS+1)'(min_x_reg);
        wy_reg  <= (WORD_BITS+1)'(max_y_reg) - (WORD_BITS+1)'(min_y_reg);
        lvl_reg <= level;
    end

    // Stage 2: saturation decision and divider operands
    assign num_x = scale(dx_reg);
    assign num_y = scale(dy_reg);

    always_comb
    begin
        side_s2_next.lvl    = lvl_reg;
        side_s2_next.x_mode = classify(dx_reg, wx_reg);
        side_s2_next.y_mode = classify(dy_reg, wy_reg);
        side_s2_next.bad    = (wx_reg <= 0) || (wy_reg <= 0);
    end

    always_ff @(posedge clk)
    begin
        side_s2_reg <= side_s2_next;
        hi_x_reg    <= num_x[WORD_BITS+COORD_BITS-1:COORD_BITS];
        hi_y_reg    <= num_y[WORD_BITS+COORD_BITS-1:COORD_BITS];
        lo_x_reg    <= num_x[COORD_BITS-1:0];
        lo_y_reg    <= num_y[COORD_BITS-1:0];
        div_x_reg   <= wx_reg[WORD_BITS-1:0];
        div_y_reg   <= wy_reg[WORD_BITS-1:0];
    end

    // Dividers, one per axis
    ptqk_div #(.COORD_BITS(COORD_BITS)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_hi     (hi_x_reg),
        .in_lo     (lo_x_reg),
        .in_div    (div_x_reg),
        .out_valid (qx_valid),
        .out_quo   (quo_x)
    );

    ptqk_div #(.COORD_BITS(COORD_BITS)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_hi     (hi_y_reg),
        .in_lo     (lo_y_reg),
        .in_div    (div_y_reg),
        .out_valid (qy_valid),
        .out_quo   (quo_y)
    );

    // Delay the sideband alongside the dividers
    always_ff @(posedge clk)
    begin
        side_pipe_reg[1] <= side_s2_reg;
        for (int i = 2; i <= COORD_BITS; i++)
        begin
            side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    // Key framing and result registers
    ptqk_keygen #(
        .COORD_BITS (COORD_BITS),
        .MAX_LEVEL  (MAX_LEVEL)
    ) u_keygen (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (qx_valid && qy_valid),
        .side              (side_pipe_reg[COORD_BITS]),
        .quo_x             (quo_x),
        .quo_y             (quo_y),
        .done              (done),
        .tile_key          (tile_key),
        .degenerate_bounds (degenerate_bounds)
    );

    // A result beat always traces back to a start beat
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without matching start");

    // The marker bit keeps every key nonzero
    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> tile_key != '0)
        else $error("quad key is zero");

    // Depth zero yields the bare marker
    a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(level, LATENCY) == '0) |-> tile_key == KEY_BITS'(1))
        else $error("depth zero key is not one");

endmodule

// ===== bench/point_to_quad_key_core_tb.sv =====
// Self-checking bench for the point-to-quad-key core: directed table, degenerate regions, then random points.
`timescale 1ns / 1ps

module point_to_quad_key_core_tb
    import ptqk_pkg::*;
();

    localparam int LATENCY   = 35;
    localparam int WD_LIMIT  = 2000;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                bad;
    } key_beat_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [4:0]         lvl;
        logic               has_exp;
        logic [62:0]        key;
        logic               bad;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [WORD_BITS-1:0] point_x = '0;
    logic signed [WORD_BITS-1:0] point_y = '0;
    logic [LVL_BITS-1:0]         level = '0;
    logic                        done;
    logic [KEY_BITS-1:0]         tile_key;
    logic                        degenerate_bounds;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [7:0]                  cfg_index = '0;
    logic [WORD_BITS-1:0]        cfg_data = '0;

    // Bench copy of the region registers
    logic signed [31:0] bnd_min_x, bnd_min_y, bnd_max_x, bnd_max_y;
    key_beat_t          key_queue[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 pin_next = 0;

    point_to_quad_key_core dut (.*);

    always #5 clk = ~clk;

    // Watchdog: count cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("point_to_quad_key_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Check each result beat against the oldest expected key
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (key_queue.size() == 0)
                report_mismatch("result with no pending point");
            else
            begin
                key_beat_t e;
                e = key_queue.pop_front();
                if (tile_key !== e.key)
                    report_mismatch($sformatf("tile_key %h exp %h", tile_key, e.key));
                if (degenerate_bounds !== e.bad)
                    report_mismatch($sformatf("degenerate_bounds %b exp %b",
                                              degenerate_bounds, e.bad));
            end
        end
    end

    function automatic logic [31:0] cell_of(input logic signed [31:0] c,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi,
                                            inout logic bad);
        logic signed [33:0] w, d;
        logic [65:0] prod;
        w = 34'(hi) - 34'(lo);
        d = 34'(c) - 34'(lo);
        if (w <= 0)
        begin
            bad = 1'b1;
            return 32'd0;
        end
        if (d <= 0)
            return 32'd0;
        if (d >= w)
            return 32'hFFFF_FFFF;
        prod = 66'(d) * 66'h0_FFFF_FFFF;
        return 32'(prod / 66'(w));
    endfunction

    function automatic logic [63:0] spread(input logic [31:0] v);
        logic [63:0] s;
        s = '0;
        for (int i = 0; i < 32; i++)
            s[2*i] = v[i];
        return s;
    endfunction

    function automatic key_beat_t predict_key(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic [4:0] lvl);
        key_beat_t   r;
        logic        bad;
        logic [63:0] morton, key;
        bad = 1'b0;
        morton = spread(cell_of(px, bnd_min_x, bnd_max_x, bad))
               | (spread(cell_of(py, bnd_min_y, bnd_max_y, bad)) << 1);
        key = 64'd1 << (2 * lvl);
        if (lvl != 0)
            key |= morton >> (64 - 2 * lvl);
        r.key = key[62:0];
        r.bad = bad;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(9) < 6)
            return 0;
        if ($urandom_range(19) == 0)
            return $urandom_range(60, 10);
        return $urandom_range(3, 1);
    endfunction

    // Drive one config beat and mirror it
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MIN_X: bnd_min_x = val;
            REG_MIN_Y: bnd_min_y = val;
            REG_MAX_X: bnd_max_x = val;
            REG_MAX_Y: bnd_max_y = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_region(input logic [31:0] x0, input logic [31:0] y0,
                              input logic [31:0] x1, input logic [31:0] y1);
        write_reg(REG_MIN_X, x0);
        write_reg(REG_MIN_Y, y0);
        write_reg(REG_MAX_X, x1);
        write_reg(REG_MAX_Y, y1);
    endtask

    // Hold start until the beat is taken; keep start high into back-to-back beats
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic [4:0] lvl, input key_beat_t e);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (g) @(negedge clk);
        end
        else
            @(negedge clk);
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        level   <= lvl;
        do @(posedge clk); while (busy);
        key_queue = {key_queue, e};
    endtask

    task automatic send_predicted(input logic signed [31:0] px,
                                  input logic signed [31:0] py, input logic [4:0] lvl);
        send_point(px, py, lvl, predict_key(px, py, lvl));
    endtask

    // Wait out every expected result, then let the pipe empty
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (key_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi);
        logic signed [33:0] span;
        span = 34'(hi) - 34'(lo);
        case ($urandom_range(9))
            0: return $urandom();
            1: return lo + $urandom_range(2) - 1;
            2: return hi + $urandom_range(2) - 1;
            default:
                if (span > 0 && span < 34'h0_FFFF_FFFF)
                    return lo + ($urandom() % (32'(span) + 1));
                else
                    return $urandom();
        endcase
    endfunction

    dir_row_t dir_table[] = '{
        '{32'sd0,       32'sd0,       5'd0,  1'b1, 63'd1, 1'b0},
        '{32'sd0,       32'sd0,       5'd31, 1'b1, 63'h1 << 62, 1'b0},
        '{32'sd65535,   32'sd65535,   5'd31, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0},
        '{32'sd65535,   32'sd0,       5'd1,  1'b1, 63'd5, 1'b0},
        '{32'sd0,       32'sd65535,   5'd1,  1'b1, 63'd6, 1'b0},
        '{-32'sd1,      -32'sd5,      5'd3,  1'b1, 63'd64, 1'b0},
        '{32'sd70000,   32'sd99999,   5'd2,  1'b1, 63'd31, 1'b0},
        '{32'h7FFFFFFF, 32'h80000000, 5'd4,  1'b1, 63'h155, 1'b0},
        '{32'sd32768,   32'sd12345,   5'd16, 1'b0, '0, 1'b0},
        '{32'sd1,       32'sd65534,   5'd31, 1'b0, '0, 1'b0},
        '{32'sd40000,   32'sd20000,   5'd7,  1'b0, '0, 1'b0}
    };

    initial
    begin
        bnd_min_x = 0; bnd_min_y = 0; bnd_max_x = 65535; bnd_max_y = 65535;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table at reset bounds
        foreach (dir_table[i])
        begin
            key_beat_t e;
            if (dir_table[i].has_exp)
            begin
                e.key = dir_table[i].key;
                e.bad = dir_table[i].bad;
                send_point(dir_table[i].px, dir_table[i].py, dir_table[i].lvl, e);
            end
            else
                send_predicted(dir_table[i].px, dir_table[i].py, dir_table[i].lvl);
        end
        drain();

        // Degenerate and inverted axes, plus two ignored register indexes
        set_region(32'd10, 32'd10, 32'd10, 32'd500);
        write_reg(8'd4, 32'hDEAD_BEEF);
        write_reg(8'hFF, 32'h0);
        send_predicted(32'sd10, 32'sd200, 5'd5);
        send_predicted(32'sd999, 32'sd600, 5'd31);
        drain();
        set_region(32'd100, 32'd100, 32'd50, 32'd20);
        send_predicted(32'sd70, 32'sd70, 5'd31);
        send_predicted(32'sd0, 32'sd0, 5'd0);
        drain();

        // Random phases over several regions, extremes included
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_region(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                1: set_region(32'd0, 32'd0, 32'd1, 32'd1);
                2: set_region(32'h7FFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
                3: set_region(32'd0, 32'd0, 32'd65535, 32'd65535);
                4: set_region(32'd5, $urandom(), 32'd5, $urandom());
                default:
                begin
                    logic [31:0] a, b, c, d;
                    a = $urandom(); b = $urandom(); c = $urandom(); d = $urandom();
                    if ($signed(c) < $signed(a)) begin c ^= a; a ^= c; c ^= a; end
                    if ($signed(d) < $signed(b)) begin d ^= b; b ^= d; d ^= b; end
                    set_region(a, b, c, d);
                end
            endcase
            for (int n = 0; n < 150; n++)
                send_predicted(rand_coord(bnd_min_x, bnd_max_x),
                               rand_coord(bnd_min_y, bnd_max_y), 5'($urandom()));
            drain();
        end

        if (errors == 0)
            $display("point_to_quad_key_core test passed");
        else
            $display("point_to_quad_key_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/ptqk_pkg.sv
design/ptqk_div.sv
design/ptqk_keygen.sv
design/point_to_quad_key_core.sv
bench/point_to_quad_key_core_tb.sv
